FILE: rtl/core/gmbn_pkg.sv
// ----------------------------------------------------------------------------
// gmbn_pkg
// Shared types and constants of the gas mixture blend and normalize block.
// ----------------------------------------------------------------------------
package gmbn_pkg;

  localparam int NUM_GASES_DEF = 16;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_WRITE = 3'd1;
  localparam logic [2:0] CMD_PURE  = 3'd2;
  localparam logic [2:0] CMD_MIX   = 3'd3;
  localparam logic [2:0] CMD_NORM  = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  localparam logic [17:0] FRAC_MAX   = 18'h3FFFF;
  localparam logic [16:0] ONE_Q16    = 17'h10000;
  localparam logic [23:0] MASS_RESET = 24'd256;

  // Quotient bits of the shared divider; every quotient is at most one in Q1.16.
  localparam int QW    = 17;
  localparam int DEN_W = 25;
  localparam int NUM_W = DEN_W + 16;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [3:0]         comp_index;
    logic signed [23:0] inflow_amount;
    logic [16:0]        comp_fraction;
    logic               comp_present;
    logic               only_existing;
  } in_t;

  typedef struct packed {
    logic [17:0] fraction_sum;
    logic        read_present;
    logic [17:0] read_fraction;
    logic        saturated;
  } out_t;

endpackage

FILE: rtl/core/gas_mixture_blend_normalize_top.sv
// ----------------------------------------------------------------------------
// gas_mixture_blend_normalize_top
// Mole fraction store with blend, normalize, clear, write and read commands.
// ----------------------------------------------------------------------------
// Usage: one command beat enters on in_data when in_valid and in_ready are
// both high; every command returns exactly one result beat on out_data.
// The mass register mix_mass is loaded by cfg_we/cfg_data; the user must
// load it only while idle, as the block does not enforce this. Fractions
// sit in a small synchronous memory with a registered read; each entry
// has a valid bit, so an entry never written reads as zero.
// Command steps: add mixture element runs the ksi division on the shared
// 17-step restoring divider, then one read, two multiply steps and a
// write back. Add pure component does the same division, then the same
// per-entry pass applied to every component. Normalize first sums the
// present entries, then divides each present component on the shared
// divider and skips absent ones; a sum of zero or exactly one ends it.
// One command is in flight at a time; the next is taken once the previous
// result sits in the output register, even if the receiver stalls it.
// Reset empties the store at once through the valid and presence flags and
// sets mix_mass to 256.
// ----------------------------------------------------------------------------
module gas_mixture_blend_normalize_top
  import gmbn_pkg::*;
#(
  parameter int NUM_GASES = NUM_GASES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [23:0] cfg_data
);

  localparam int IW    = (NUM_GASES > 1) ? $clog2(NUM_GASES) : 1;
  localparam int SUM_W = 18 + IW;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_RD, S_MUL1, S_MUL2, S_WR,
    S_SRD, S_SACC, S_NRD, S_NST, S_RDR, S_DONE
  } state_t;

  state_t state;

  logic [23:0]          mix_mass;
  logic [2:0]           cmd;
  logic [IW-1:0]        idx;
  logic [16:0]          frac;
  logic                 inc;
  logic                 only;
  logic [IW-1:0]        cnt;
  logic [NUM_GASES-1:0] pres;
  logic [NUM_GASES-1:0] vld;

  logic [17:0]          frac_mem [NUM_GASES];
  logic [17:0]          rdata;
  logic                 rvld;

  logic [16:0]          ksi;
  logic [35:0]          acc;
  logic [16:0]          f1;
  logic                 wen;
  logic                 setp;
  logic [SUM_W-1:0]     sum;

  logic [DEN_W-1:0]     drem;
  logic [DEN_W-1:0]     dden;
  logic [16:0]          dnlo;
  logic [QW-1:0]        dq;
  logic [4:0]           dcnt;

  logic [17:0]          res_sum;
  logic                 res_rp;
  logic [17:0]          res_rf;
  logic                 sat;

  logic                 accept;
  logic                 in_ok;
  logic [IW-1:0]        maddr;
  logic [17:0]          cur_c;
  logic                 last;
  logic                 hit;
  logic [23:0]          dmag;
  logic [DEN_W-1:0]     denom;
  logic [NUM_W-1:0]     knum;
  logic [NUM_W-1:0]     nnum;
  logic [DEN_W:0]       dpart;
  logic                 dge;
  logic [DEN_W-1:0]     drem_next;
  logic [QW-1:0]        dq_next;
  logic [16:0]          ksi1;
  logic [36:0]          rnd;
  logic                 clip_sat;
  logic [17:0]          clip_val;
  logic                 mem_we;
  logic [17:0]          mem_wdata;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_ok    = 32'(in_data.comp_index) < NUM_GASES;
  assign maddr    = (state == S_IDLE) ? IW'(in_data.comp_index) : cnt;
  assign cur_c    = rvld ? rdata : 18'd0;
  assign last     = (cnt == IW'(NUM_GASES - 1));
  assign hit      = (cnt == idx);
  assign ksi1     = ONE_Q16 - ksi;

  // Magnitude of the signed inflow, and the ksi dividend rounded half up.
  assign dmag  = in_data.inflow_amount[23] ? 24'(-in_data.inflow_amount)
                                           : in_data.inflow_amount;
  assign denom = DEN_W'(mix_mass) + DEN_W'(dmag);
  assign knum  = {1'b0, mix_mass, 16'd0} + NUM_W'(denom >> 1);
  assign nnum  = NUM_W'({cur_c, 16'd0}) + NUM_W'(sum >> 1);

  // One restoring step of the shared divider.
  assign dpart     = {drem, dnlo[16]};
  assign dge       = dpart >= {1'b0, dden};
  assign drem_next = dge ? DEN_W'(dpart - {1'b0, dden}) : dpart[DEN_W-1:0];
  assign dq_next   = {dq[QW-2:0], dge};

  assign rnd      = 37'(acc) + 37'd32768;
  assign clip_sat = rnd[36:16] > 21'(FRAC_MAX);
  assign clip_val = clip_sat ? FRAC_MAX : rnd[33:16];

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = clip_val;
    unique case (state)
      S_IDLE: begin
        mem_we    = accept && (in_data.cmd == CMD_WRITE) && in_ok;
        mem_wdata = 18'(in_data.comp_fraction);
      end
      S_WR: mem_we = wen;
      S_DIV: begin
        mem_we    = (dcnt == 5'(QW - 1)) && (cmd == CMD_NORM);
        mem_wdata = 18'(dq_next);
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frac_mem[maddr] <= mem_wdata;
    end
    rdata <= frac_mem[maddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mix_mass  <= MASS_RESET;
      pres      <= '0;
      vld       <= '0;
      rvld      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        mix_mass <= cfg_data;
      end
      rvld <= vld[maddr];
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      if (mem_we) begin
        vld[maddr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd     <= in_data.cmd;
            idx     <= IW'(in_data.comp_index);
            frac    <= in_data.comp_fraction;
            inc     <= in_data.comp_present;
            only    <= in_data.only_existing;
            res_sum <= '0;
            res_rp  <= 1'b0;
            res_rf  <= '0;
            sat     <= 1'b0;
            sum     <= '0;
            case (in_data.cmd)
              CMD_CLEAR: begin
                pres  <= '0;
                vld   <= '0;
                state <= S_DONE;
              end
              CMD_WRITE: begin
                if (in_ok) begin
                  pres[IW'(in_data.comp_index)] <= in_data.comp_present;
                end
                state <= S_DONE;
              end
              CMD_PURE, CMD_MIX: begin
                cnt <= (in_data.cmd == CMD_PURE) ? '0 : IW'(in_data.comp_index);
                if (in_ok) begin
                  if (denom == '0) begin
                    ksi   <= ONE_Q16;
                    state <= S_RD;
                  end else begin
                    drem  <= DEN_W'(knum[NUM_W-1:17]);
                    dnlo  <= knum[16:0];
                    dden  <= denom;
                    dq    <= '0;
                    dcnt  <= '0;
                    state <= S_DIV;
                  end
                end else begin
                  state <= S_DONE;
                end
              end
              CMD_NORM: begin
                cnt   <= '0;
                state <= S_SRD;
              end
              CMD_READ: begin
                cnt   <= IW'(in_data.comp_index);
                state <= in_ok ? S_RDR : S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_DIV: begin
          drem <= drem_next;
          dnlo <= {dnlo[15:0], 1'b0};
          dq   <= dq_next;
          dcnt <= dcnt + 5'd1;
          if (dcnt == 5'(QW - 1)) begin
            if (cmd == CMD_NORM) begin
              if (last) begin
                state <= S_DONE;
              end else begin
                cnt   <= cnt + IW'(1);
                state <= S_NRD;
              end
            end else begin
              ksi   <= dq_next;
              state <= S_RD;
            end
          end
        end
        S_RD: state <= S_MUL1;
        S_MUL1: begin
          if (cmd == CMD_PURE) begin
            acc  <= 36'(cur_c) * 36'(pres[cnt] ? ksi : ONE_Q16);
            f1   <= hit ? ONE_Q16 : 17'd0;
            wen  <= pres[cnt] || hit;
            setp <= hit;
          end else begin
            acc  <= 36'(cur_c) * 36'(pres[cnt] ? ksi : ONE_Q16);
            f1   <= (only ? pres[cnt] : inc) ? frac : 17'd0;
            wen  <= only ? pres[cnt] : (pres[cnt] || inc);
            setp <= !only && inc;
          end
          state <= S_MUL2;
        end
        S_MUL2: begin
          acc   <= acc + 36'(ksi1) * 36'(f1);
          state <= S_WR;
        end
        S_WR: begin
          if (wen) begin
            sat <= sat | clip_sat;
            if (setp) begin
              pres[cnt] <= 1'b1;
            end
          end
          if ((cmd == CMD_PURE) && !last) begin
            cnt   <= cnt + IW'(1);
            state <= S_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_SRD: state <= S_SACC;
        S_SACC: begin
          if (pres[cnt]) begin
            sum <= sum + SUM_W'(cur_c);
          end
          if (last) begin
            cnt   <= '0;
            state <= S_NRD;
          end else begin
            cnt   <= cnt + IW'(1);
            state <= S_SRD;
          end
        end
        S_NRD: begin
          if (32'(sum) > 32'(FRAC_MAX)) begin
            res_sum <= FRAC_MAX;
            sat     <= 1'b1;
          end else begin
            res_sum <= 18'(sum);
          end
          if ((sum == '0) || (sum == SUM_W'(ONE_Q16))) begin
            state <= S_DONE;
          end else begin
            state <= S_NST;
          end
        end
        S_NST: begin
          if (pres[cnt]) begin
            drem  <= DEN_W'(nnum[NUM_W-1:17]);
            dnlo  <= nnum[16:0];
            dden  <= DEN_W'(sum);
            dq    <= '0;
            dcnt  <= '0;
            state <= S_DIV;
          end else if (last) begin
            state <= S_DONE;
          end else begin
            cnt   <= cnt + IW'(1);
            state <= S_NRD;
          end
        end
        S_RDR: begin
          res_rp <= pres[cnt];
          res_rf <= cur_c;
          state  <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data.fraction_sum  <= res_sum;
            out_data.read_present  <= res_rp;
            out_data.read_fraction <= res_rf;
            out_data.saturated     <= sat;
            out_valid              <= 1'b1;
            state                  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A component can only be present after its entry has been written.
  a_pres_has_data: assert property (@(posedge clk) disable iff (rst)
    (pres & ~vld) == '0)
    else $error("present component without stored fraction");

  // Clear empties the store in the cycle after the command beat.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && (in_data.cmd == CMD_CLEAR) |=> (pres == '0) && (vld == '0))
    else $error("clear left entries behind");

  // The divider never runs on a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (dden != '0))
    else $error("division by zero");

  // Quotients are weights or normalized fractions, never above one.
  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && (dcnt == 5'(QW - 1)) |-> (dq_next <= ONE_Q16))
    else $error("quotient above one");

endmodule
